FILE: sv/mhtq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mhtq_pkg
// Shared types and constants of the min-heap timer queue.
// ----------------------------------------------------------------------------
package mhtq_pkg;

  localparam int CAPACITY    = 64;
  localparam int TIME_BITS   = 32;
  localparam int ID_COUNT    = 64;
  localparam int MAX_RESULTS = 64;
  localparam int QUEUE_DEPTH = 2;

  localparam int ID_W   = 6;
  localparam int OUT_TW = 32;
  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int N_W    = $clog2(MAX_RESULTS + 1);
  localparam int FLAG_W = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
  localparam int QP_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W   = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TICK   = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    RS_ADDED     = 3'd0,
    RS_FULL      = 3'd1,
    RS_CANCELLED = 3'd2,
    RS_FIRED     = 3'd3,
    RS_EXP_CANC  = 3'd4,
    RS_IDLE      = 3'd5
  } status_t;

  typedef struct packed {
    op_t                  op;
    logic [ID_W-1:0]      id;
    logic [TIME_BITS-1:0] tm;
  } cmd_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] tm;
    logic [ID_W-1:0]      id;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SU_RD,
    ST_SU_CMP,
    ST_ADD_DONE,
    ST_TK_RD,
    ST_TK_CHK,
    ST_TK_LAST,
    ST_SD_A,
    ST_SD_B,
    ST_SD_C,
    ST_SD_D
  } state_t;

endpackage
`default_nettype wire

FILE: sv/min_heap_timer_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// min_heap_timer_queue
// Timer queue on a binary min-heap with lazy cancel and tick-driven expiry.
// ----------------------------------------------------------------------------
// Items pass through a two-entry command queue to a heap engine that works on
// one command at a time against a single-port heap memory with registered
// read. A cancel or a rejected add is answered from the idle state; an add
// climbs the heap one level per parent read, then reports; a tick reads the
// root to check it, and each popped entry sinks one level per round of child
// reads. A tick pops at most MAX_RESULTS entries; a result is held in an
// output register, so the engine keeps working while the previous result
// waits, and stalls only when it has the next result to give.
module min_heap_timer_queue (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_stall,
  input  wire  [1:0]                 in_kind,
  input  wire  [mhtq_pkg::ID_W-1:0]  in_timer_id,
  input  wire  [31:0]                in_expire_time,
  input  wire  [31:0]                in_now,
  output logic                       out_valid,
  input  wire                        out_stall,
  output logic [2:0]                 out_status,
  output logic [mhtq_pkg::ID_W-1:0]  out_timer_id,
  output logic [31:0]                out_expire_time,
  output logic                       out_last
);

  logic           cmd_valid;
  logic           cmd_pop;
  mhtq_pkg::cmd_t cmd;

  // accept and queue commands
  mhtq_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_timer_id    (in_timer_id),
    .in_expire_time (in_expire_time),
    .in_now         (in_now),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop)
  );

  // run heap operations
  mhtq_engine u_engine (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_pop         (cmd_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_timer_id    (out_timer_id),
    .out_expire_time (out_expire_time),
    .out_last        (out_last)
  );

endmodule
`default_nettype wire

FILE: sv/mhtq_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mhtq_front
// Accepts input items, decodes their kind and queues commands for the engine.
// ----------------------------------------------------------------------------
module mhtq_front (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire  [1:0]                    in_kind,
  input  wire  [mhtq_pkg::ID_W-1:0]     in_timer_id,
  input  wire  [31:0]                   in_expire_time,
  input  wire  [31:0]                   in_now,
  output logic                          cmd_valid,
  output mhtq_pkg::cmd_t                cmd,
  input  wire                           cmd_pop
);

  mhtq_pkg::cmd_t              q_r [mhtq_pkg::QUEUE_DEPTH];
  logic [mhtq_pkg::QP_W-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [mhtq_pkg::QC_W-1:0]   cnt_r, cnt_nxt;
  mhtq_pkg::cmd_t              dec;
  logic                        dec_ok;
  logic                        push;
  logic                        pop;

  // decode the kind; an unused kind is dropped
  always_comb begin
    dec.id = in_timer_id;
    dec.op = mhtq_pkg::OP_ADD;
    dec.tm = mhtq_pkg::TIME_BITS'(in_expire_time);
    dec_ok = 1'b1;
    case (mhtq_pkg::op_t'(in_kind))
      mhtq_pkg::OP_ADD: begin
        dec.op = mhtq_pkg::OP_ADD;
      end
      mhtq_pkg::OP_CANCEL: begin
        dec.op = mhtq_pkg::OP_CANCEL;
      end
      mhtq_pkg::OP_TICK: begin
        dec.op = mhtq_pkg::OP_TICK;
        dec.tm = mhtq_pkg::TIME_BITS'(in_now);
      end
      default: begin
        dec_ok = 1'b0;
      end
    endcase
  end

  assign in_stall  = (cnt_r == mhtq_pkg::QC_W'(mhtq_pkg::QUEUE_DEPTH));
  assign push      = in_valid && !in_stall && dec_ok;
  assign pop       = cmd_pop && (cnt_r != '0);
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rp_r];

  // advance pointers, wrapping at the queue depth
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == mhtq_pkg::QP_W'(mhtq_pkg::QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == mhtq_pkg::QP_W'(mhtq_pkg::QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // hold queued commands
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= dec;
    end
  end

endmodule
`default_nettype wire

FILE: sv/mhtq_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mhtq_engine
// Carries out queued commands on the heap memory and registers each result.
// ----------------------------------------------------------------------------
module mhtq_engine (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           cmd_valid,
  input  mhtq_pkg::cmd_t                cmd,
  output logic                          cmd_pop,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic [2:0]                    out_status,
  output logic [mhtq_pkg::ID_W-1:0]     out_timer_id,
  output logic [31:0]                   out_expire_time,
  output logic                          out_last
);

  localparam int CW = mhtq_pkg::IDX_W + 2;

  mhtq_pkg::entry_t             heap_mem [mhtq_pkg::CAPACITY];
  mhtq_pkg::entry_t             rd_r;
  logic                         mem_we, mem_re;
  logic [mhtq_pkg::IDX_W-1:0]   mem_waddr, mem_raddr;
  mhtq_pkg::entry_t             mem_wdata;

  mhtq_pkg::state_t             state_r, state_nxt;
  logic [mhtq_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [mhtq_pkg::N_W-1:0]     n_r, n_nxt;
  logic [mhtq_pkg::ID_COUNT-1:0] flags_r, flags_nxt;
  logic [mhtq_pkg::IDX_W-1:0]   pos_r, pos_nxt, par_r, par_nxt, bidx_r, bidx_nxt;
  mhtq_pkg::entry_t             mv_r, mv_nxt, best_r, best_nxt;
  logic [mhtq_pkg::TIME_BITS-1:0] now_r, now_nxt;
  mhtq_pkg::status_t            pst_r, pst_nxt;
  mhtq_pkg::entry_t             pend_r, pend_nxt;

  logic                         ov_r, ol_r;
  mhtq_pkg::status_t            os_r;
  logic [mhtq_pkg::ID_W-1:0]    oid_r;
  logic [31:0]                  ot_r;

  logic                         emit, e_last;
  mhtq_pkg::status_t            e_st;
  logic [mhtq_pkg::ID_W-1:0]    e_id;
  logic [31:0]                  e_tm;

  logic                         out_free, full, pop_due, cmd_id_ok, rd_id_ok, rd_canc;
  logic [CW-1:0]                c_full, c1_full, cnt_ext;
  logic [mhtq_pkg::IDX_W-1:0]   parent;

  assign out_free  = !ov_r || !out_stall;
  assign full      = (count_r >= mhtq_pkg::CNT_W'(mhtq_pkg::CAPACITY));
  assign pop_due   = (count_r != '0) && (n_r < mhtq_pkg::N_W'(mhtq_pkg::MAX_RESULTS))
                     && (rd_r.tm <= now_r);
  assign cmd_id_ok = (32'(cmd.id) < mhtq_pkg::ID_COUNT);
  assign rd_id_ok  = (32'(rd_r.id) < mhtq_pkg::ID_COUNT);
  assign rd_canc   = rd_id_ok && flags_r[mhtq_pkg::FLAG_W'(rd_r.id)];
  assign c_full    = CW'({pos_r, 1'b1});
  assign c1_full   = c_full + 1'b1;
  assign cnt_ext   = CW'(count_r);
  assign parent    = (pos_r - 1'b1) >> 1;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mhtq_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.op == mhtq_pkg::OP_ADD && !full) begin
            state_nxt = mhtq_pkg::ST_SU_RD;
          end else if (cmd.op == mhtq_pkg::OP_TICK) begin
            state_nxt = mhtq_pkg::ST_TK_RD;
          end
        end
      end
      mhtq_pkg::ST_SU_RD: begin
        state_nxt = (pos_r == '0) ? mhtq_pkg::ST_ADD_DONE : mhtq_pkg::ST_SU_CMP;
      end
      mhtq_pkg::ST_SU_CMP: begin
        state_nxt = (rd_r.tm <= mv_r.tm) ? mhtq_pkg::ST_ADD_DONE : mhtq_pkg::ST_SU_RD;
      end
      mhtq_pkg::ST_ADD_DONE: begin
        if (out_free) begin
          state_nxt = mhtq_pkg::ST_IDLE;
        end
      end
      mhtq_pkg::ST_TK_RD: begin
        state_nxt = mhtq_pkg::ST_TK_CHK;
      end
      mhtq_pkg::ST_TK_CHK: begin
        if (pop_due) begin
          if (n_r == '0 || out_free) begin
            state_nxt = mhtq_pkg::ST_TK_LAST;
          end
        end else if (out_free) begin
          state_nxt = mhtq_pkg::ST_IDLE;
        end
      end
      mhtq_pkg::ST_TK_LAST: begin
        state_nxt = mhtq_pkg::ST_SD_A;
      end
      mhtq_pkg::ST_SD_A: begin
        state_nxt = (c_full >= cnt_ext) ? mhtq_pkg::ST_TK_RD : mhtq_pkg::ST_SD_B;
      end
      mhtq_pkg::ST_SD_B: begin
        state_nxt = (c1_full < cnt_ext) ? mhtq_pkg::ST_SD_C : mhtq_pkg::ST_SD_D;
      end
      mhtq_pkg::ST_SD_C: begin
        state_nxt = mhtq_pkg::ST_SD_D;
      end
      mhtq_pkg::ST_SD_D: begin
        state_nxt = (best_r.tm < mv_r.tm) ? mhtq_pkg::ST_SD_A : mhtq_pkg::ST_TK_RD;
      end
      default: begin
        state_nxt = mhtq_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath, memory controls and results
  always_comb begin
    count_nxt = count_r;
    n_nxt     = n_r;
    flags_nxt = flags_r;
    pos_nxt   = pos_r;
    par_nxt   = par_r;
    bidx_nxt  = bidx_r;
    mv_nxt    = mv_r;
    best_nxt  = best_r;
    now_nxt   = now_r;
    pst_nxt   = pst_r;
    pend_nxt  = pend_r;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = pos_r;
    mem_raddr = '0;
    mem_wdata = mv_r;
    cmd_pop   = 1'b0;
    emit      = 1'b0;
    e_st      = mhtq_pkg::RS_IDLE;
    e_id      = '0;
    e_tm      = '0;
    e_last    = 1'b1;
    case (state_r)
      mhtq_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            mhtq_pkg::OP_ADD: begin
              if (full) begin
                if (out_free) begin
                  cmd_pop = 1'b1;
                  emit    = 1'b1;
                  e_st    = mhtq_pkg::RS_FULL;
                  e_id    = cmd.id;
                end
              end else begin
                cmd_pop   = 1'b1;
                mv_nxt.tm = cmd.tm;
                mv_nxt.id = cmd.id;
                pos_nxt   = mhtq_pkg::IDX_W'(count_r);
                if (cmd_id_ok) begin
                  flags_nxt[mhtq_pkg::FLAG_W'(cmd.id)] = 1'b0;
                end
              end
            end
            mhtq_pkg::OP_CANCEL: begin
              if (out_free) begin
                cmd_pop = 1'b1;
                emit    = 1'b1;
                e_st    = mhtq_pkg::RS_CANCELLED;
                e_id    = cmd.id;
                if (cmd_id_ok) begin
                  flags_nxt[mhtq_pkg::FLAG_W'(cmd.id)] = 1'b1;
                end
              end
            end
            mhtq_pkg::OP_TICK: begin
              cmd_pop = 1'b1;
              now_nxt = cmd.tm;
              n_nxt   = '0;
            end
            default: begin
              cmd_pop = 1'b1;
            end
          endcase
        end
      end
      // sift up: move larger parents down until the new entry fits
      mhtq_pkg::ST_SU_RD: begin
        if (pos_r == '0) begin
          mem_we    = 1'b1;
          count_nxt = count_r + 1'b1;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = parent;
          par_nxt   = parent;
        end
      end
      mhtq_pkg::ST_SU_CMP: begin
        mem_we = 1'b1;
        if (rd_r.tm <= mv_r.tm) begin
          count_nxt = count_r + 1'b1;
        end else begin
          mem_wdata = rd_r;
          pos_nxt   = par_r;
        end
      end
      mhtq_pkg::ST_ADD_DONE: begin
        if (out_free) begin
          emit = 1'b1;
          e_st = mhtq_pkg::RS_ADDED;
          e_id = mv_r.id;
        end
      end
      mhtq_pkg::ST_TK_RD: begin
        mem_re = 1'b1;
      end
      // pop the root if due; release the previous pop once its successor is known
      mhtq_pkg::ST_TK_CHK: begin
        if (pop_due) begin
          if (n_r == '0 || out_free) begin
            if (n_r != '0) begin
              emit   = 1'b1;
              e_st   = pst_r;
              e_id   = pend_r.id;
              e_tm   = mhtq_pkg::OUT_TW'(pend_r.tm);
              e_last = 1'b0;
            end
            pend_nxt  = rd_r;
            pst_nxt   = rd_canc ? mhtq_pkg::RS_EXP_CANC : mhtq_pkg::RS_FIRED;
            n_nxt     = n_r + 1'b1;
            count_nxt = count_r - 1'b1;
            mem_re    = 1'b1;
            mem_raddr = mhtq_pkg::IDX_W'(count_r - 1'b1);
          end
        end else if (out_free) begin
          emit = 1'b1;
          if (n_r != '0) begin
            e_st = pst_r;
            e_id = pend_r.id;
            e_tm = mhtq_pkg::OUT_TW'(pend_r.tm);
          end
        end
      end
      mhtq_pkg::ST_TK_LAST: begin
        mv_nxt  = rd_r;
        pos_nxt = '0;
      end
      // sift down: fetch children one at a time, keep the smaller
      mhtq_pkg::ST_SD_A: begin
        if (c_full >= cnt_ext) begin
          mem_we = 1'b1;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = mhtq_pkg::IDX_W'(c_full);
        end
      end
      mhtq_pkg::ST_SD_B: begin
        best_nxt = rd_r;
        bidx_nxt = mhtq_pkg::IDX_W'(c_full);
        if (c1_full < cnt_ext) begin
          mem_re    = 1'b1;
          mem_raddr = mhtq_pkg::IDX_W'(c1_full);
        end
      end
      mhtq_pkg::ST_SD_C: begin
        if (rd_r.tm < best_r.tm) begin
          best_nxt = rd_r;
          bidx_nxt = mhtq_pkg::IDX_W'(c1_full);
        end
      end
      mhtq_pkg::ST_SD_D: begin
        mem_we = 1'b1;
        if (best_r.tm < mv_r.tm) begin
          mem_wdata = best_r;
          pos_nxt   = bidx_r;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // heap memory with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      heap_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_r <= heap_mem[mem_raddr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mhtq_pkg::ST_IDLE;
      count_r <= '0;
      n_r     <= '0;
      flags_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      n_r     <= n_nxt;
      flags_r <= flags_nxt;
      if (emit) begin
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  // working and result payload
  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    par_r  <= par_nxt;
    bidx_r <= bidx_nxt;
    mv_r   <= mv_nxt;
    best_r <= best_nxt;
    now_r  <= now_nxt;
    pst_r  <= pst_nxt;
    pend_r <= pend_nxt;
    if (emit) begin
      os_r  <= e_st;
      oid_r <= e_id;
      ot_r  <= e_tm;
      ol_r  <= e_last;
    end
  end

  assign out_valid       = ov_r;
  assign out_status      = os_r;
  assign out_timer_id    = oid_r;
  assign out_expire_time = ot_r;
  assign out_last        = ol_r;

endmodule
`default_nettype wire

FILE: tb/min_heap_timer_queue_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_heap_timer_queue_chk
// Watches both channels of the timer queue, keeps its own heap and cancel
// flags, predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module min_heap_timer_queue_chk (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  input  wire                          in_stall,
  input  wire  [1:0]                   in_kind,
  input  wire  [mhtq_pkg::ID_W-1:0]    in_timer_id,
  input  wire  [31:0]                  in_expire_time,
  input  wire  [31:0]                  in_now,
  input  wire                          out_valid,
  input  wire                          out_stall,
  input  wire  [2:0]                   out_status,
  input  wire  [mhtq_pkg::ID_W-1:0]    out_timer_id,
  input  wire  [31:0]                  out_expire_time,
  input  wire                          out_last,
  output int                           fail_count,
  output int                           pending,
  output int                           heap_size
);

  typedef struct packed {
    mhtq_pkg::status_t st;
    logic [5:0]        id;
    logic [31:0]       tm;
    logic              lst;
  } timer_result_t;

  logic [31:0]   heap_tm [mhtq_pkg::CAPACITY];
  logic [5:0]    heap_id [mhtq_pkg::CAPACITY];
  bit            canc_flag [mhtq_pkg::ID_COUNT];
  int            count;
  timer_result_t due_q [$];

  assign pending   = due_q.size();
  assign heap_size = count;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    begin
      $display("mismatch %s: got %0d, want %0d", what, got, want);
      fail_count++;
    end
  endtask

  function automatic timer_result_t mk(mhtq_pkg::status_t st, logic [5:0] id,
                                      logic [31:0] tm, logic lst);
    timer_result_t r;
    r.st = st; r.id = id; r.tm = tm; r.lst = lst;
    return r;
  endfunction

  // Insert at the first free slot and climb.
  task automatic heap_insert(input logic [31:0] t, input logic [5:0] id);
    int pos;
    int up;
    begin
      pos = count;
      while (pos > 0) begin
        up = (pos - 1) / 2;
        if (heap_tm[up] <= t) break;
        heap_tm[pos] = heap_tm[up];
        heap_id[pos] = heap_id[up];
        pos = up;
      end
      heap_tm[pos] = t;
      heap_id[pos] = id;
      count++;
    end
  endtask

  // Move the last entry to the root and sink it.
  task automatic heap_pop();
    int pos;
    int c;
    logic [31:0] t;
    logic [5:0] id;
    begin
      count--;
      heap_tm[0] = heap_tm[count];
      heap_id[0] = heap_id[count];
      pos = 0;
      t = heap_tm[0];
      id = heap_id[0];
      while (count > 0 && pos * 2 + 1 <= count - 1) begin
        c = pos * 2 + 1;
        if (c < count - 1 && heap_tm[c+1] < heap_tm[c]) c++;
        if (heap_tm[c] < t) begin
          heap_tm[pos] = heap_tm[c];
          heap_id[pos] = heap_id[c];
          pos = c;
        end else break;
      end
      heap_tm[pos] = t;
      heap_id[pos] = id;
    end
  endtask

  task automatic predict_item(input logic [1:0] kind, input logic [5:0] id,
                              input logic [31:0] et, input logic [31:0] now);
    int n;
    begin
      case (kind)
        mhtq_pkg::OP_ADD: begin
          if (count >= mhtq_pkg::CAPACITY)
            due_q.push_back(mk(mhtq_pkg::RS_FULL, id, 0, 1'b1));
          else begin
            canc_flag[id] = 1'b0;
            heap_insert(et, id);
            due_q.push_back(mk(mhtq_pkg::RS_ADDED, id, 0, 1'b1));
          end
        end
        mhtq_pkg::OP_CANCEL: begin
          canc_flag[id] = 1'b1;
          due_q.push_back(mk(mhtq_pkg::RS_CANCELLED, id, 0, 1'b1));
        end
        mhtq_pkg::OP_TICK: begin
          n = 0;
          while (n < mhtq_pkg::MAX_RESULTS && count > 0 && heap_tm[0] <= now) begin
            due_q.push_back(mk(canc_flag[heap_id[0]] ? mhtq_pkg::RS_EXP_CANC
                                                     : mhtq_pkg::RS_FIRED,
                               heap_id[0], heap_tm[0], 1'b0));
            n++;
            heap_pop();
          end
          if (n == 0) due_q.push_back(mk(mhtq_pkg::RS_IDLE, 0, 0, 1'b1));
          else due_q[$].lst = 1'b1;
        end
        default: ;
      endcase
    end
  endtask

  // Predict on each accepted item, compare each accepted result.
  always @(posedge clk) begin
    timer_result_t want;
    if (!rst_n) begin
      count = 0;
      fail_count = 0;
      due_q.delete();
      foreach (canc_flag[i]) canc_flag[i] = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_q.size() == 0) report("unexpected result, status", out_status, 0);
        else begin
          want = due_q.pop_front();
          if (out_status !== want.st) report("status", out_status, want.st);
          if (out_timer_id !== want.id) report("timer id", out_timer_id, want.id);
          if (out_expire_time !== want.tm) report("expiry", out_expire_time, want.tm);
          if (out_last !== want.lst) report("last", out_last, want.lst);
        end
      end
      if (in_valid && !in_stall)
        predict_item(in_kind, in_timer_id, in_expire_time, in_now);
    end
  end

endmodule

FILE: tb/min_heap_timer_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_heap_timer_queue_tb
// Drives add, cancel and tick items into the timer queue in bursts, with a
// stalling receiver; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module min_heap_timer_queue_tb;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [1:0]                in_kind = mhtq_pkg::OP_TICK;
  logic [mhtq_pkg::ID_W-1:0] in_timer_id = '0;
  logic [31:0]               in_expire_time = '0;
  logic [31:0]               in_now = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [2:0]                out_status;
  logic [mhtq_pkg::ID_W-1:0] out_timer_id;
  logic [31:0]               out_expire_time;
  logic                      out_last;
  int                        fail_count;
  int                        pending;
  int                        heap_size;
  bit                        hold_off = 1'b0;
  bit                        hold_go = 1'b0;
  logic [31:0]               clock_now = 0;

  always #1 clk = ~clk;

  min_heap_timer_queue u_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_kind, .in_timer_id,
    .in_expire_time, .in_now, .out_valid, .out_stall, .out_status,
    .out_timer_id, .out_expire_time, .out_last
  );

  min_heap_timer_queue_chk u_chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_kind, .in_timer_id,
    .in_expire_time, .in_now, .out_valid, .out_stall, .out_status,
    .out_timer_id, .out_expire_time, .out_last, .fail_count, .pending,
    .heap_size
  );

  // Offer one item and hold it until accepted.
  task automatic send_item(input mhtq_pkg::op_t k, input logic [5:0] id,
                           input logic [31:0] et, input logic [31:0] now);
    begin
      in_valid <= 1'b1;
      in_kind <= k;
      in_timer_id <= id;
      in_expire_time <= et;
      in_now <= now;
      do @(posedge clk); while (in_stall);
      @(negedge clk);
    end
  endtask

  task automatic gap(input int n);
    begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic drain();
    begin
      in_valid <= 1'b0;
      @(negedge clk);
      while (pending != 0) @(negedge clk);
      repeat (20) @(negedge clk);
    end
  endtask

  // Receiver stalls on its own pattern, with one long hold-off on request.
  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else if (($urandom % 64) < 20) out_stall <= ($urandom_range(0, 2) != 0);
    else out_stall <= 1'b0;
  end

  // Hold the receiver off for a long stretch once asked.
  initial begin
    wait (hold_go);
    hold_off = 1'b1;
    repeat (300) @(negedge clk);
    hold_off = 1'b0;
  end

  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int burst;
    int r;
    logic [31:0] et;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty tick, extremes, cancel and re-add, unused kind.
    send_item(mhtq_pkg::OP_TICK, 6'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(mhtq_pkg::OP_ADD, 6'd63, 32'hFFFF_FFFF, 0);
    send_item(mhtq_pkg::OP_ADD, 6'd0, 32'd0, 0);
    send_item(mhtq_pkg::OP_ADD, 6'd42, 32'd5, 0);
    send_item(mhtq_pkg::OP_ADD, 6'd21, 32'd5, 0);
    send_item(mhtq_pkg::OP_CANCEL, 6'd42, 0, 32'hFFFF_FFFF);
    send_item(mhtq_pkg::OP_CANCEL, 6'd17, 0, 0);
    send_item(mhtq_pkg::OP_TICK, 6'd63, 0, 32'd0);
    send_item(mhtq_pkg::OP_TICK, 6'd0, 0, 32'd4);
    send_item(mhtq_pkg::OP_TICK, 6'd0, 0, 32'd5);
    send_item(mhtq_pkg::OP_CANCEL, 6'd63, 0, 0);
    send_item(mhtq_pkg::OP_ADD, 6'd63, 32'h8000_0000, 0);
    send_item(mhtq_pkg::op_t'(2'd3), 6'd9, 32'd1, 32'hFFFF_FFFF);
    send_item(mhtq_pkg::OP_TICK, 6'd0, 0, 32'hFFFF_FFFF);
    drain();

    // Fill past capacity while the receiver holds off, then drain in one tick.
    hold_go = 1'b1;
    for (int i = 0; i < mhtq_pkg::CAPACITY + 2; i++)
      send_item(mhtq_pkg::OP_ADD, 6'($urandom), $urandom_range(0, 1000), 0);
    send_item(mhtq_pkg::OP_TICK, 0, 0, 32'hFFFF_FFFF);
    drain();

    // Random bursts with a moving clock.
    r = 0;
    while (r < 20) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst; b++) begin
        case ($urandom % 10)
          0, 1, 2, 3: begin
            et = ($urandom % 8 == 0) ? $urandom : clock_now + $urandom_range(0, 200);
            send_item(heap_size < mhtq_pkg::CAPACITY - 4 ? mhtq_pkg::OP_ADD
                                                         : mhtq_pkg::OP_TICK,
                      6'($urandom), et, clock_now);
          end
          4, 5: send_item(mhtq_pkg::OP_CANCEL, 6'($urandom), $urandom, $urandom);
          6: send_item(mhtq_pkg::op_t'(2'd3), 6'($urandom), $urandom, $urandom);
          default: begin
            clock_now = clock_now + $urandom_range(0, 80);
            send_item(mhtq_pkg::OP_TICK, 6'($urandom), $urandom,
                      ($urandom % 16 == 0) ? $urandom : clock_now);
          end
        endcase
        r++;
      end
      if ($urandom % 8 == 0) drain();
      else gap($urandom_range(0, 6));
    end
    send_item(mhtq_pkg::OP_TICK, 0, 0, 32'hFFFF_FFFF);
    in_valid <= 1'b0;

    // Wait for the last results, bounded.
    for (int w = 0; w < 100000 && pending != 0; w++) @(negedge clk);
    repeat (50) @(negedge clk);
    if (fail_count == 0 && pending == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
sv/mhtq_pkg.sv
sv/mhtq_front.sv
sv/mhtq_engine.sv
sv/min_heap_timer_queue.sv
tb/min_heap_timer_queue_chk.sv
tb/min_heap_timer_queue_tb.sv
